// ----- sv/ncfl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncfl_pkg
// Shared types and constants of the chunk free-list allocator.
// ----------------------------------------------------------------------------
package ncfl_pkg;

    localparam int CHUNK_W     = 10;
    localparam int LINK_W      = 11;
    localparam int CNT_W       = 11;
    localparam int EXT_W       = 6;
    localparam int STAT_W      = 3;
    localparam int NODE_IN_W   = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int STORE_DEPTH = 1024;

    localparam logic [LINK_W-1:0] EMPTY_MARK = 11'd1024;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_LOCAL_ALLOC  = 3'd0;
    localparam logic [STAT_W-1:0] ST_GLOBAL_ALLOC = 3'd1;
    localparam logic [STAT_W-1:0] ST_OUT_OF_MEM   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FREED_LOCAL  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FREED_GLOBAL = 3'd4;
    localparam logic [STAT_W-1:0] ST_FREE_IGNORED = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_LIMIT = 1'd1;

    localparam logic [CNT_W-1:0] CACHE_LIMIT_RST  = 11'd8;
    localparam logic [EXT_W-1:0] EXTENT_LIMIT_RST = 6'd32;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_FILL,
        S_GCHK,
        S_LPOP,
        S_GPOP,
        S_FTAG,
        S_RESP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic latch_in;
        logic clear_step;
        logic lpop_rd;
        logic lpop_wb;
        logic refill_start;
        logic fill_step;
        logic gpop_rd;
        logic gpop_wb;
        logic tag_rd;
        logic free_wb;
        logic set_oom;
        logic load_out;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_free;
        logic local_avail;
        logic global_avail;
        logic refill_ok;
        logic fill_done;
        logic clr_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- sv/ncfl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncfl_ctrl
// Sequencer: steps one request through the datapath at a time.
// ----------------------------------------------------------------------------
module ncfl_ctrl
    import ncfl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.is_free) begin
                    o_cmd.tag_rd = 1'b1;
                    n_state      = S_FTAG;
                end else if (i_stat.local_avail) begin
                    o_cmd.lpop_rd = 1'b1;
                    n_state       = S_LPOP;
                end else if (!i_stat.global_avail && i_stat.refill_ok) begin
                    o_cmd.refill_start = 1'b1;
                    n_state            = S_FILL;
                end else begin
                    n_state = S_GCHK;
                end
            end
            S_FILL: begin
                if (i_stat.fill_done) begin
                    n_state = S_GCHK;
                end else begin
                    o_cmd.fill_step = 1'b1;
                end
            end
            S_GCHK: begin
                if (i_stat.global_avail) begin
                    o_cmd.gpop_rd = 1'b1;
                    n_state       = S_GPOP;
                end else begin
                    o_cmd.set_oom = 1'b1;
                    n_state       = S_RESP;
                end
            end
            S_LPOP: begin
                o_cmd.lpop_wb = 1'b1;
                n_state       = S_RESP;
            end
            S_GPOP: begin
                o_cmd.gpop_wb = 1'b1;
                n_state       = S_RESP;
            end
            S_FTAG: begin
                o_cmd.free_wb = 1'b1;
                n_state       = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/ncfl_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncfl_dp
// Datapath: link and tag memories, stack heads and counts, extent refill,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module ncfl_dp
    import ncfl_pkg::*;
#(
    parameter int NODE_COUNT        = 4,
    parameter int CHUNKS_PER_EXTENT = 32,
    parameter int MAX_EXTENTS       = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_command,
    input  logic [NODE_IN_W-1:0]  i_node,
    input  logic [CHUNK_W-1:0]    i_chunk_index,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [CHUNK_W-1:0]    o_granted_chunk,
    output logic [STAT_W-1:0]     o_status
);

    localparam int NW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int FIW = $clog2(CHUNKS_PER_EXTENT + 1);
    localparam int BW  = (EXT_W + FIW > LINK_W) ? EXT_W + FIW : LINK_W;
    localparam int MXW = EXT_W + 1;

    // node numbers are below four, so at most three subtractions
    function automatic logic [NODE_IN_W-1:0] node_mod(input logic [NODE_IN_W-1:0] v);
        logic [4:0] w;
        w = {3'b0, v};
        for (int k = 0; k < 3; k++) begin
            if (w >= 5'(NODE_COUNT)) begin
                w = w - 5'(NODE_COUNT);
            end
        end
        return NODE_IN_W'(w);
    endfunction

    function automatic logic [LINK_W-1:0] next_of(input logic [LINK_W-1:0] d);
        return d[LINK_W-1] ? EMPTY_MARK : d;
    endfunction

    // memories
    logic [LINK_W-1:0]    r_link_mem [STORE_DEPTH];
    logic [NODE_IN_W:0]   r_tag_mem  [STORE_DEPTH];   // {initialized, owner}
    logic [LINK_W-1:0]    r_link_q;
    logic [NODE_IN_W:0]   r_tag_q;

    // control state
    logic [CNT_W-1:0]     r_cache_limit;
    logic [EXT_W-1:0]     r_extent_limit;
    logic [LINK_W-1:0]    r_node_head  [NODE_COUNT];
    logic [CNT_W-1:0]     r_node_count [NODE_COUNT];
    logic [LINK_W-1:0]    r_global_head;
    logic [EXT_W-1:0]     r_extents;
    logic [CHUNK_W-1:0]   r_clr_idx;
    logic                 r_o_valid;

    // payload
    logic                 r_cmd;
    logic [NW-1:0]        r_node;
    logic [CHUNK_W-1:0]   r_chunk;
    logic [FIW-1:0]       r_fill_i;
    logic [BW-1:0]        r_fill_c;
    logic [CHUNK_W-1:0]   r_res_chunk;
    logic [STAT_W-1:0]    r_res_status;
    logic [CHUNK_W-1:0]   r_o_granted;
    logic [STAT_W-1:0]    r_o_status;

    logic                 link_we;
    logic [CHUNK_W-1:0]   link_waddr;
    logic [LINK_W-1:0]    link_wdata;
    logic [CHUNK_W-1:0]   link_raddr;
    logic                 tag_we;
    logic [CHUNK_W-1:0]   tag_waddr;
    logic [NODE_IN_W:0]   tag_wdata;
    logic [NW-1:0]        free_t;
    logic                 fits_local;
    logic [LINK_W-1:0]    local_head;

    assign local_head = r_node_head[r_node];
    assign free_t     = NW'(node_mod(r_tag_q[NODE_IN_W-1:0]));
    assign fits_local = r_node_count[free_t] < r_cache_limit;

    assign o_stat.is_free      = (r_cmd == CMD_FREE);
    assign o_stat.local_avail  = !local_head[LINK_W-1];
    assign o_stat.global_avail = !r_global_head[LINK_W-1];
    assign o_stat.refill_ok    = (r_extents < r_extent_limit)
                              && ({1'b0, r_extents} < MXW'(MAX_EXTENTS));
    assign o_stat.fill_done    = (r_fill_i == FIW'(CHUNKS_PER_EXTENT))
                              || (r_fill_c >= BW'(STORE_DEPTH));
    assign o_stat.clr_last     = (r_clr_idx == CHUNK_W'(STORE_DEPTH - 1));
    assign o_stat.out_free     = !r_o_valid || i_ready;

    // memory port selection
    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_chunk;
        link_wdata = r_global_head;
        if (i_cmd.fill_step) begin
            link_we    = 1'b1;
            link_waddr = r_fill_c[CHUNK_W-1:0];
        end else if (i_cmd.free_wb && r_tag_q[NODE_IN_W]) begin
            link_we    = 1'b1;
            link_wdata = fits_local ? r_node_head[free_t] : r_global_head;
        end
        link_raddr = i_cmd.lpop_rd ? local_head[CHUNK_W-1:0]
                                   : r_global_head[CHUNK_W-1:0];

        tag_we    = i_cmd.clear_step || i_cmd.gpop_rd;
        tag_waddr = i_cmd.clear_step ? r_clr_idx : r_global_head[CHUNK_W-1:0];
        tag_wdata = i_cmd.clear_step ? '0 : {1'b1, NODE_IN_W'(r_node)};
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_waddr] <= link_wdata;
        end
        if (i_cmd.lpop_rd || i_cmd.gpop_rd) begin
            r_link_q <= r_link_mem[link_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_tag_mem[tag_waddr] <= tag_wdata;
        end
        if (i_cmd.tag_rd) begin
            r_tag_q <= r_tag_mem[r_chunk];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_limit  <= CACHE_LIMIT_RST;
            r_extent_limit <= EXTENT_LIMIT_RST;
            for (int n = 0; n < NODE_COUNT; n++) begin
                r_node_head[n]  <= EMPTY_MARK;
                r_node_count[n] <= '0;
            end
            r_global_head  <= EMPTY_MARK;
            r_extents      <= '0;
            r_clr_idx      <= '0;
            r_o_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CACHE_LIMIT:  r_cache_limit  <= i_cfg_data;
                    CFG_EXTENT_LIMIT: r_extent_limit <= i_cfg_data[EXT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clear_step) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cmd.refill_start) begin
                r_extents <= r_extents + 1'b1;
            end
            if (i_cmd.fill_step) begin
                r_global_head <= LINK_W'(r_fill_c);
            end
            if (i_cmd.lpop_wb) begin
                r_node_head[r_node] <= next_of(r_link_q);
                if (r_node_count[r_node] != '0) begin
                    r_node_count[r_node] <= r_node_count[r_node] - 1'b1;
                end
            end
            if (i_cmd.gpop_wb) begin
                r_global_head <= next_of(r_link_q);
            end
            if (i_cmd.free_wb && r_tag_q[NODE_IN_W]) begin
                if (fits_local) begin
                    r_node_head[free_t]  <= {1'b0, r_chunk};
                    r_node_count[free_t] <= r_node_count[free_t] + 1'b1;
                end else begin
                    r_global_head <= {1'b0, r_chunk};
                end
            end
            if (i_cmd.load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_cmd   <= i_command;
            r_node  <= NW'(node_mod(i_node));
            r_chunk <= i_chunk_index;
        end
        if (i_cmd.refill_start) begin
            r_fill_i <= '0;
            r_fill_c <= BW'(r_extents) * BW'(CHUNKS_PER_EXTENT);
        end else if (i_cmd.fill_step) begin
            r_fill_i <= r_fill_i + 1'b1;
            r_fill_c <= r_fill_c + 1'b1;
        end
        if (i_cmd.lpop_wb) begin
            r_res_chunk  <= local_head[CHUNK_W-1:0];
            r_res_status <= ST_LOCAL_ALLOC;
        end else if (i_cmd.gpop_wb) begin
            r_res_chunk  <= r_global_head[CHUNK_W-1:0];
            r_res_status <= ST_GLOBAL_ALLOC;
        end else if (i_cmd.set_oom) begin
            r_res_chunk  <= '0;
            r_res_status <= ST_OUT_OF_MEM;
        end else if (i_cmd.free_wb) begin
            r_res_chunk <= '0;
            if (!r_tag_q[NODE_IN_W]) begin
                r_res_status <= ST_FREE_IGNORED;
            end else if (fits_local) begin
                r_res_status <= ST_FREED_LOCAL;
            end else begin
                r_res_status <= ST_FREED_GLOBAL;
            end
        end
        if (i_cmd.load_out) begin
            r_o_granted <= r_res_chunk;
            r_o_status  <= r_res_status;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_granted_chunk = r_o_granted;
    assign o_status        = r_o_status;

endmodule

// ----- sv/numa_chunk_free_list_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numa_chunk_free_list_allocator
// Two-level free-list chunk allocator with a free stack per node and a
// global stack refilled one extent at a time.
//
//   channel  handshake                  payload                             dir
//   request  i_valid / o_ready          i_command, i_node, i_chunk_index    in
//   result   o_valid / i_ready          o_granted_chunk, o_status           out
//   config   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data            in
//
// One request at a time. Local alloc: decide, local pop, response; free:
// decide, tag read, response; global alloc: decide, global check, global
// pop, response, with an extent fill pass first when the stack is refilled.
// After reset a pass clears all 1024 tag entries; o_ready stays low meanwhile.
// A stalled result holds in the output register; the next request is
// taken once the result is loaded there. Config writes are always taken.
// ----------------------------------------------------------------------------
module numa_chunk_free_list_allocator
    import ncfl_pkg::*;
#(
    parameter int NODE_COUNT        = 4,
    parameter int CHUNKS_PER_EXTENT = 32,
    parameter int MAX_EXTENTS       = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_command,
    input  logic [NODE_IN_W-1:0]  i_node,
    input  logic [CHUNK_W-1:0]    i_chunk_index,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [CHUNK_W-1:0]    o_granted_chunk,
    output logic [STAT_W-1:0]     o_status,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    ncfl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    ncfl_dp #(
        .NODE_COUNT        (NODE_COUNT),
        .CHUNKS_PER_EXTENT (CHUNKS_PER_EXTENT),
        .MAX_EXTENTS       (MAX_EXTENTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_command       (i_command),
        .i_node          (i_node),
        .i_chunk_index   (i_chunk_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_granted_chunk (o_granted_chunk),
        .o_status        (o_status)
    );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the chunk free-list allocator. A directed table
// covers out of memory, ignored frees, extent refill order, double frees, the
// local count underflow and the config extremes. Random phases follow, mostly
// allocs and frees of chunks currently handed out, with a few frees of
// never-used chunks. Every transfer is predicted by a behavioral copy of the
// node stacks, the global stack and the extent counter, and every result is
// compared against that prediction.
// ----------------------------------------------------------------------------
module tb
    import ncfl_pkg::*;
();

    localparam int     NODES          = 4;
    localparam int     CHUNKS_PER_EXT = 32;
    localparam int     MAX_EXT        = 32;
    localparam int     CLK_HALF       = 10;
    localparam int     RST_CYCLES     = 9;
    localparam int     SETTLE_CYCLES  = 4;
    localparam int     TAIL_CYCLES    = 40;
    localparam int     HOLD_CYCLES    = 80;
    localparam int     DRAIN_LIMIT    = 5000;
    localparam int     REPORT_MAX     = 10;
    localparam int     NOISE_PCT      = 6;
    localparam longint LIMIT_NS       = 10_000_000;

    typedef struct packed {
        logic [CHUNK_W-1:0] chunk;
        logic [STAT_W-1:0]  status;
    } t_grant;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    // reg_sel is only meaningful on config rows, value is the chunk index
    // on request rows and the write data on config rows
    typedef struct packed {
        t_row_kind             kind;
        logic                  cmd;
        logic [NODE_IN_W-1:0]  node;
        logic [CFG_IDX_W-1:0]  reg_sel;
        logic [CFG_DATA_W-1:0] value;
        logic                  typed;
        t_grant                want;
    } t_plan_row;

    localparam t_grant NO_WANT  = '0;
    localparam int     PLAN_LEN = 28;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_command;
    logic [NODE_IN_W-1:0]  i_node;
    logic [CHUNK_W-1:0]    i_chunk_index;
    logic                  o_valid;
    logic                  i_ready;
    logic [CHUNK_W-1:0]    o_granted_chunk;
    logic [STAT_W-1:0]     o_status;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // allocator image
    logic [LINK_W-1:0] pool_link [STORE_DEPTH];
    logic [1:0]        pool_tag  [STORE_DEPTH];
    logic              pool_init [STORE_DEPTH];
    logic [LINK_W-1:0] local_top [NODES];
    logic [CNT_W-1:0]  local_cnt [NODES];
    logic [LINK_W-1:0] shared_top;
    logic [EXT_W-1:0]  extents_used;
    logic [CNT_W-1:0]  lim_cache;
    logic [EXT_W-1:0]  lim_extent;

    t_grant             grants_due [$];
    logic [CHUNK_W-1:0] chunks_out [$];
    int                 mismatches = 0;
    bit                 gaps_on    = 1'b1;
    bit                 long_hold  = 1'b0;
    int                 stall_left = 0;

    t_plan_row plan [PLAN_LEN] = '{
        // nothing may be taken: out of memory, then frees of unused chunks
        '{ROW_CFG, CMD_ALLOC, 2'd0, CFG_EXTENT_LIMIT, 11'd0,    1'b0, NO_WANT},
        '{ROW_REQ, CMD_ALLOC, 2'd0, CFG_CACHE_LIMIT,  11'd0,    1'b1, {10'd0, ST_OUT_OF_MEM}},
        '{ROW_REQ, CMD_FREE,  2'd3, CFG_CACHE_LIMIT,  11'd0,    1'b1, {10'd0, ST_FREE_IGNORED}},
        '{ROW_REQ, CMD_FREE,  2'd0, CFG_CACHE_LIMIT,  11'd1023, 1'b1, {10'd0, ST_FREE_IGNORED}},
        // first extent, highest chunk on top
        '{ROW_CFG, CMD_ALLOC, 2'd0, CFG_EXTENT_LIMIT, 11'd1,    1'b0, NO_WANT},
        '{ROW_REQ, CMD_ALLOC, 2'd3, CFG_CACHE_LIMIT,  11'd1023, 1'b1, {10'd31, ST_GLOBAL_ALLOC}},
        '{ROW_REQ, CMD_ALLOC, 2'd2, CFG_CACHE_LIMIT,  11'd0,    1'b1, {10'd30, ST_GLOBAL_ALLOC}},
        '{ROW_REQ, CMD_FREE,  2'd0, CFG_CACHE_LIMIT,  11'd31,   1'b1, {10'd0, ST_FREED_LOCAL}},
        '{ROW_REQ, CMD_ALLOC, 2'd3, CFG_CACHE_LIMIT,  11'd0,    1'b0, NO_WANT},
        // no local caching at all
        '{ROW_CFG, CMD_ALLOC, 2'd0, CFG_CACHE_LIMIT,  11'd0,    1'b0, NO_WANT},
        '{ROW_REQ, CMD_FREE,  2'd1, CFG_CACHE_LIMIT,  11'd31,   1'b1, {10'd0, ST_FREED_GLOBAL}},
        '{ROW_REQ, CMD_FREE,  2'd1, CFG_CACHE_LIMIT,  11'd30,   1'b1, {10'd0, ST_FREED_GLOBAL}},
        // double frees onto the local stacks cut the global chain short
        '{ROW_CFG, CMD_ALLOC, 2'd0, CFG_CACHE_LIMIT,  11'd1024, 1'b0, NO_WANT},
        '{ROW_REQ, CMD_FREE,  2'd0, CFG_CACHE_LIMIT,  11'd31,   1'b0, NO_WANT},
        '{ROW_REQ, CMD_FREE,  2'd0, CFG_CACHE_LIMIT,  11'd30,   1'b0, NO_WANT},
        '{ROW_REQ, CMD_ALLOC, 2'd2, CFG_CACHE_LIMIT,  11'd0,    1'b0, NO_WANT},
        '{ROW_REQ, CMD_ALLOC, 2'd2, CFG_CACHE_LIMIT,  11'd0,    1'b0, NO_WANT},
        // self-linked entry: pops keep returning it, count stuck at zero
        '{ROW_REQ, CMD_FREE,  2'd0, CFG_CACHE_LIMIT,  11'd31,   1'b0, NO_WANT},
        '{ROW_REQ, CMD_ALLOC, 2'd3, CFG_CACHE_LIMIT,  11'd0,    1'b0, NO_WANT},
        '{ROW_REQ, CMD_ALLOC, 2'd3, CFG_CACHE_LIMIT,  11'd0,    1'b0, NO_WANT},
        '{ROW_REQ, CMD_ALLOC, 2'd3, CFG_CACHE_LIMIT,  11'd0,    1'b0, NO_WANT},
        // push to the empty global stack breaks the loop
        '{ROW_CFG, CMD_ALLOC, 2'd0, CFG_CACHE_LIMIT,  11'd0,    1'b0, NO_WANT},
        '{ROW_REQ, CMD_FREE,  2'd2, CFG_CACHE_LIMIT,  11'd31,   1'b0, NO_WANT},
        '{ROW_REQ, CMD_ALLOC, 2'd3, CFG_CACHE_LIMIT,  11'd0,    1'b0, NO_WANT},
        '{ROW_REQ, CMD_ALLOC, 2'd3, CFG_CACHE_LIMIT,  11'd0,    1'b0, NO_WANT},
        // extent limit hit, then lifted
        '{ROW_REQ, CMD_ALLOC, 2'd1, CFG_CACHE_LIMIT,  11'd0,    1'b1, {10'd0, ST_OUT_OF_MEM}},
        '{ROW_CFG, CMD_ALLOC, 2'd0, CFG_EXTENT_LIMIT, 11'd32,   1'b0, NO_WANT},
        '{ROW_REQ, CMD_ALLOC, 2'd1, CFG_CACHE_LIMIT,  11'd0,    1'b1, {10'd63, ST_GLOBAL_ALLOC}}
    };

    always #(CLK_HALF) i_clk = ~i_clk;

    numa_chunk_free_list_allocator #(
        .NODE_COUNT       (NODES),
        .CHUNKS_PER_EXTENT(CHUNKS_PER_EXT),
        .MAX_EXTENTS      (MAX_EXT)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_node         (i_node),
        .i_chunk_index  (i_chunk_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_granted_chunk(o_granted_chunk),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    function automatic logic [LINK_W-1:0] link_after(input logic [LINK_W-1:0] c);
        logic [LINK_W-1:0] nxt;
        nxt = pool_link[c[CHUNK_W-1:0]];
        return (nxt >= EMPTY_MARK) ? EMPTY_MARK : nxt;
    endfunction

    // one alloc or free against the allocator image
    task automatic expected_grant(input logic cmd, input logic [1:0] node,
                                  input logic [CHUNK_W-1:0] chunk, output t_grant res);
        logic [LINK_W-1:0] c;
        logic [1:0]        owner;
        int                base;
        int                i;
        res = '0;
        if (cmd == CMD_ALLOC) begin
            if (local_top[node] < EMPTY_MARK) begin
                c = local_top[node];
                local_top[node] = link_after(c);
                if (local_cnt[node] > 0) begin
                    local_cnt[node] = local_cnt[node] - 1'b1;
                end
                res.chunk  = c[CHUNK_W-1:0];
                res.status = ST_LOCAL_ALLOC;
            end else begin
                if (shared_top >= EMPTY_MARK && extents_used < lim_extent &&
                    extents_used < MAX_EXT) begin
                    base = int'(extents_used) * CHUNKS_PER_EXT;
                    extents_used = extents_used + 1'b1;
                    for (i = 0; i < CHUNKS_PER_EXT && base + i < STORE_DEPTH; i++) begin
                        pool_link[CHUNK_W'(base + i)] = shared_top;
                        shared_top = LINK_W'(base + i);
                    end
                end
                if (shared_top < EMPTY_MARK) begin
                    c = shared_top;
                    shared_top = link_after(c);
                    pool_tag[c[CHUNK_W-1:0]]  = node;
                    pool_init[c[CHUNK_W-1:0]] = 1'b1;
                    res.chunk  = c[CHUNK_W-1:0];
                    res.status = ST_GLOBAL_ALLOC;
                end else begin
                    res.status = ST_OUT_OF_MEM;
                end
            end
        end else if (!pool_init[chunk]) begin
            res.status = ST_FREE_IGNORED;
        end else begin
            owner = pool_tag[chunk];
            if (local_cnt[owner] < lim_cache) begin
                pool_link[chunk] = local_top[owner];
                local_top[owner] = {1'b0, chunk};
                local_cnt[owner] = local_cnt[owner] + 1'b1;
                res.status = ST_FREED_LOCAL;
            end else begin
                pool_link[chunk] = shared_top;
                shared_top = {1'b0, chunk};
                res.status = ST_FREED_GLOBAL;
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    task automatic idle_gap();
        if (gaps_on && $urandom_range(0, 99) < 25) begin
            if (i_valid) i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // leaves i_valid high at the transfer edge; the caller decides what follows
    task automatic send_req(input logic cmd, input logic [1:0] node,
                            input logic [CHUNK_W-1:0] chunk, input bit track,
                            input bit typed, input t_grant want);
        t_grant res;
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_node        <= node;
        i_chunk_index <= chunk;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_grant(cmd, node, chunk, res);
        if (track && (res.status == ST_LOCAL_ALLOC || res.status == ST_GLOBAL_ALLOC)) begin
            chunks_out.push_back(res.chunk);
        end
        grants_due.push_back(typed ? want : res);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] value);
        if (i_valid) i_valid <= 1'b0;
        while (grants_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (sel == CFG_CACHE_LIMIT) begin
            lim_cache = value;
        end else begin
            lim_extent = value[EXT_W-1:0];
        end
    endtask

    // mostly allocs and frees of chunks in use, plus frees of unused chunks
    task automatic run_phase(input int items, input int alloc_pct, input int hold_at);
        int                 k;
        int                 pick;
        int                 roll;
        logic [CHUNK_W-1:0] idx;
        logic [1:0]         nd;
        for (k = 0; k < items; k++) begin
            idle_gap();
            if (k == hold_at) long_hold = 1'b1;
            roll = $urandom_range(0, 99);
            idx  = CHUNK_W'($urandom_range(0, STORE_DEPTH - 1));
            nd   = 2'($urandom_range(0, NODES - 1));
            if (roll < NOISE_PCT && !pool_init[idx]) begin
                send_req(CMD_FREE, nd, idx, 1'b1, 1'b0, NO_WANT);
            end else if (roll >= alloc_pct && chunks_out.size() != 0) begin
                pick = $urandom_range(0, chunks_out.size() - 1);
                idx  = chunks_out[pick];
                chunks_out.delete(pick);
                send_req(CMD_FREE, nd, idx, 1'b1, 1'b0, NO_WANT);
            end else begin
                send_req(CMD_ALLOC, nd, idx, 1'b1, 1'b0, NO_WANT);
            end
        end
    endtask

    // receiver: short random stalls, and one long hold-off on request
    initial begin
        i_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (long_hold) begin
                long_hold  = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                i_ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 99) < 20) begin
                stall_left = $urandom_range(0, 3);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_grant want;
        if (i_rst_n && o_valid && i_ready) begin
            if (grants_due.size() == 0) begin
                flag_mismatch("result with none pending, status", -1, int'(o_status));
            end else begin
                want = grants_due.pop_front();
                if (o_granted_chunk !== want.chunk) begin
                    flag_mismatch("granted_chunk", int'(want.chunk), int'(o_granted_chunk));
                end
                if (o_status !== want.status) begin
                    flag_mismatch("status", int'(want.status), int'(o_status));
                end
            end
        end
    end

    initial begin : stimulus
        int n;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_command     <= CMD_ALLOC;
        i_node        <= '0;
        i_chunk_index <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_CACHE_LIMIT;
        i_cfg_data    <= '0;
        for (n = 0; n < STORE_DEPTH; n++) begin
            pool_link[n] = '0;
            pool_tag[n]  = '0;
            pool_init[n] = 1'b0;
        end
        for (n = 0; n < NODES; n++) begin
            local_top[n] = EMPTY_MARK;
            local_cnt[n] = '0;
        end
        shared_top   = EMPTY_MARK;
        extents_used = '0;
        lim_cache    = CACHE_LIMIT_RST;
        lim_extent   = EXTENT_LIMIT_RST;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < PLAN_LEN; n++) begin
            if (plan[n].kind == ROW_CFG) begin
                write_reg(plan[n].reg_sel, plan[n].value);
            end else begin
                idle_gap();
                send_req(plan[n].cmd, plan[n].node, plan[n].value[CHUNK_W-1:0],
                         1'b0, plan[n].typed, plan[n].want);
            end
        end

        // small extent budget so out of memory comes up; long stall midway
        write_reg(CFG_CACHE_LIMIT, 11'd8);
        write_reg(CFG_EXTENT_LIMIT, 11'd4);
        run_phase(300, 70, 100);

        write_reg(CFG_CACHE_LIMIT, 11'd0);
        write_reg(CFG_EXTENT_LIMIT, 11'd8);
        run_phase(300, 50, -1);

        write_reg(CFG_CACHE_LIMIT, 11'd1023);
        write_reg(CFG_EXTENT_LIMIT, 11'd32);
        run_phase(300, 60, -1);

        // limit below what is already taken, full rate on both sides
        write_reg(CFG_CACHE_LIMIT, 11'd2);
        write_reg(CFG_EXTENT_LIMIT, 11'd5);
        gaps_on = 1'b0;
        run_phase(300, 65, -1);

        i_valid <= 1'b0;
        n = 0;
        while (grants_due.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (grants_due.size() != 0) begin
            mismatches += grants_due.size();
            $display("%0t: %0d results never arrived", $time, grants_due.size());
        end
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule
